// ===== sv/crd_pkg.sv =====
package crd_pkg;

   // grid geometry
   localparam int MAX_SIDE = 1024;
   localparam int CNT_W    = $clog2(MAX_SIDE);
   localparam int SIDE_W   = CNT_W + 1;

   // field widths
   localparam int CLR_W    = 16;
   localparam int ENTRY_W  = 2 * CLR_W;
   localparam int GRID_W   = 11;
   localparam int CELL_W   = 24;
   localparam int COORD_W  = 32;
   localparam int IDX_W    = 10;

   // register file
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int REG_IX_W = 3;

   localparam logic [REG_IX_W-1:0] REG_GRID_SIZE     = 3'd0;
   localparam logic [REG_IX_W-1:0] REG_MIN_CLEARANCE = 3'd1;
   localparam logic [REG_IX_W-1:0] REG_ORIGIN_X      = 3'd2;
   localparam logic [REG_IX_W-1:0] REG_ORIGIN_Y      = 3'd3;
   localparam logic [REG_IX_W-1:0] REG_CELL_SIZE     = 3'd4;

   localparam logic [GRID_W-1:0] GRID_SIZE_RESET = GRID_W'(1024);
   localparam logic [CELL_W-1:0] CELL_SIZE_RESET = CELL_W'(65536);

   // line store write port, entry holds {older, newer}
   typedef struct packed {
      logic               en;
      logic [CNT_W-1:0]   addr;
      logic [ENTRY_W-1:0] data;
   } line_wr_type;

   // ridge cell handed to the coordinate pipeline
   typedef struct packed {
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] row;
   } point_req_type;

endpackage

// ===== sv/crd_line_store.sv =====
module crd_line_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [crd_pkg::CNT_W-1:0]     rd_addr,
   input  crd_pkg::line_wr_type          wr,
   output logic [crd_pkg::ENTRY_W-1:0]   rd_data
);

   logic [crd_pkg::ENTRY_W-1:0] mem [crd_pkg::MAX_SIDE];
   logic [crd_pkg::ENTRY_W-1:0] q_ff;
   logic [crd_pkg::ENTRY_W-1:0] fwd_data_ff;
   logic                        fwd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         q_ff        <= mem[rd_addr];
         fwd_data_ff <= wr.data;
      end
   end

   // same-entry write in the read cycle wins over the stale array data
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr.en && (wr.addr == rd_addr);
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : q_ff;

endmodule

// ===== sv/crd_point_calc.sv =====
module crd_point_calc (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pt_valid,
   input  crd_pkg::point_req_type              pt_req,
   output logic                                pt_ready,
   input  logic [crd_pkg::CELL_W-1:0]          cell_size,
   input  logic signed [crd_pkg::COORD_W-1:0]  corner_x,
   input  logic signed [crd_pkg::COORD_W-1:0]  corner_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [crd_pkg::COORD_W-1:0]  rsp_point_x,
   output logic signed [crd_pkg::COORD_W-1:0]  rsp_point_y,
   output logic [crd_pkg::IDX_W-1:0]           rsp_cell_col,
   output logic [crd_pkg::IDX_W-1:0]           rsp_cell_row
);

   localparam int PROD_W = crd_pkg::IDX_W + 1 + crd_pkg::CELL_W;
   localparam int SUM_W  = PROD_W + 2;

   function automatic logic [crd_pkg::COORD_W-1:0] sat_centre(
      input logic [crd_pkg::COORD_W-1:0] origin,
      input logic [PROD_W-1:0]           prod
   );
      logic [PROD_W:0]  rounded;
      logic [SUM_W-1:0] sum;
      logic [crd_pkg::COORD_W-1:0] res;
      rounded = {1'b0, prod} + (PROD_W+1)'(1);
      sum = {{(SUM_W-crd_pkg::COORD_W){origin[crd_pkg::COORD_W-1]}}, origin}
          + {2'b00, rounded[PROD_W:1]};
      if (!sum[SUM_W-1] && (sum[SUM_W-2:crd_pkg::COORD_W-1] != '0)) begin
         res = {1'b0, {(crd_pkg::COORD_W-1){1'b1}}};
      end else if (sum[SUM_W-1] && !(&sum[SUM_W-2:crd_pkg::COORD_W-1])) begin
         res = {1'b1, {(crd_pkg::COORD_W-1){1'b0}}};
      end else begin
         res = sum[crd_pkg::COORD_W-1:0];
      end
      return res;
   endfunction

   logic              a_valid_ff;
   logic [PROD_W-1:0] a_prod_x_ff;
   logic [PROD_W-1:0] a_prod_y_ff;
   crd_pkg::point_req_type a_req_ff;
   logic              a_go;
   logic              b_valid_ff;

   assign a_go     = !b_valid_ff || !rsp_stall;
   assign pt_ready = !a_valid_ff || a_go;

   // stage a: (2*index + 1) * cell_size
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (pt_ready) begin
         a_valid_ff <= pt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pt_ready && pt_valid) begin
         a_prod_x_ff <= PROD_W'({pt_req.col, 1'b1}) * PROD_W'(cell_size);
         a_prod_y_ff <= PROD_W'({pt_req.row, 1'b1}) * PROD_W'(cell_size);
         a_req_ff    <= pt_req;
      end
   end

   // stage b: round, add origin, saturate
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_go) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_go && a_valid_ff) begin
         rsp_point_x  <= sat_centre(corner_x, a_prod_x_ff);
         rsp_point_y  <= sat_centre(corner_y, a_prod_y_ff);
         rsp_cell_col <= a_req_ff.col;
         rsp_cell_row <= a_req_ff.row;
      end
   end

   assign rsp_valid = b_valid_ff;

endmodule

// ===== sv/clearance_ridge_detector_unit.sv =====
// Ridge detector over a square clearance grid streamed in raster order, one
// cell per req beat (frame_start marks cell 0,0; after the last cell the grid
// wraps on its own). A cell is reported once the cell below it arrives, as a
// rsp beat carrying its column, row and world-space centre
// origin + (index + 0.5) * cell_size in Q16.16, saturated to 32 bits. The
// block takes one cell per clock cycle unless a ridge point stalls; that figure
// is set by the line store, a 1024 x 32 memory holding the two previous rows,
// read once and written once each cycle. A result is built by line store
// read, multiply and round/add/saturate. The line store needs no clearing pass:
// stale entries only reach border cells. Registers sit at byte offsets 0x00
// grid_size, 0x04 min_clearance, 0x08 origin_x, 0x0c origin_y, 0x10 cell_size,
// written by the user only while idle, which the block does not enforce.
module clearance_ridge_detector_unit (
   input  logic                                clock,
   input  logic                                reset,
   // cell stream
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [crd_pkg::CLR_W-1:0]           req_clearance,
   input  logic                                req_frame_start,
   // ridge points
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [crd_pkg::COORD_W-1:0]  rsp_point_x,
   output logic signed [crd_pkg::COORD_W-1:0]  rsp_point_y,
   output logic [crd_pkg::IDX_W-1:0]           rsp_cell_col,
   output logic [crd_pkg::IDX_W-1:0]           rsp_cell_row,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [crd_pkg::ADDR_W-1:0]          csr_paddr,
   input  logic [crd_pkg::DATA_W-1:0]          csr_pwdata,
   output logic [crd_pkg::DATA_W-1:0]          csr_prdata,
   output logic                                csr_pready
);

   localparam int CW = crd_pkg::CNT_W;
   localparam int SW = crd_pkg::SIDE_W;
   localparam int LW = crd_pkg::CLR_W;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   logic [crd_pkg::GRID_W-1:0]          grid_size_ff;
   logic [LW-1:0]                       min_clearance_ff;
   logic signed [crd_pkg::COORD_W-1:0]  corner_x_ff;
   logic signed [crd_pkg::COORD_W-1:0]  corner_y_ff;
   logic [crd_pkg::CELL_W-1:0]          cell_size_ff;
   logic                                csr_wr;
   logic [crd_pkg::REG_IX_W-1:0]        csr_ix;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_ix     = csr_paddr[crd_pkg::ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff     <= crd_pkg::GRID_SIZE_RESET;
         min_clearance_ff <= '0;
         corner_x_ff      <= '0;
         corner_y_ff      <= '0;
         cell_size_ff     <= crd_pkg::CELL_SIZE_RESET;
      end else if (csr_wr) begin
         case (csr_ix)
            crd_pkg::REG_GRID_SIZE: begin
               grid_size_ff <= csr_pwdata[crd_pkg::GRID_W-1:0];
            end
            crd_pkg::REG_MIN_CLEARANCE: begin
               min_clearance_ff <= csr_pwdata[LW-1:0];
            end
            crd_pkg::REG_ORIGIN_X: begin
               corner_x_ff <= csr_pwdata;
            end
            crd_pkg::REG_ORIGIN_Y: begin
               corner_y_ff <= csr_pwdata;
            end
            crd_pkg::REG_CELL_SIZE: begin
               cell_size_ff <= csr_pwdata[crd_pkg::CELL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_ix)
         crd_pkg::REG_GRID_SIZE: begin
            csr_prdata = crd_pkg::DATA_W'(grid_size_ff);
         end
         crd_pkg::REG_MIN_CLEARANCE: begin
            csr_prdata = crd_pkg::DATA_W'(min_clearance_ff);
         end
         crd_pkg::REG_ORIGIN_X: begin
            csr_prdata = corner_x_ff;
         end
         crd_pkg::REG_ORIGIN_Y: begin
            csr_prdata = corner_y_ff;
         end
         crd_pkg::REG_CELL_SIZE: begin
            csr_prdata = crd_pkg::DATA_W'(cell_size_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // grid side clamped to 3 .. MAX_SIDE
   logic [SW-1:0] side;

   always_comb begin
      if (grid_size_ff < crd_pkg::GRID_W'(3)) begin
         side = SW'(3);
      end else if (grid_size_ff > crd_pkg::GRID_W'(crd_pkg::MAX_SIDE)) begin
         side = SW'(crd_pkg::MAX_SIDE);
      end else begin
         side = SW'(grid_size_ff);
      end
   end

   // ---------------------------------------------------------------------
   // stage 0: raster position, line store read of column c+1
   // ---------------------------------------------------------------------
   logic [CW-1:0] col_cnt_ff, col_cnt_in;
   logic [CW-1:0] row_cnt_ff, row_cnt_in;
   logic [SW-1:0] col_w, row_w, col_nx, row_nx;
   logic [CW-1:0] cur_col, cur_row;
   logic          cur_last;
   logic          accept;

   always_comb begin
      col_w = req_frame_start ? '0 : SW'(col_cnt_ff);
      row_w = req_frame_start ? '0 : SW'(row_cnt_ff);
      // a shrunk grid size pushes the position onto the next row or grid
      if (col_w >= side) begin
         col_w = '0;
         row_w = row_w + SW'(1);
      end
      if (row_w >= side) begin
         row_w = '0;
      end
      cur_col  = col_w[CW-1:0];
      cur_row  = row_w[CW-1:0];
      col_nx   = col_w + SW'(1);
      row_nx   = row_w + SW'(1);
      cur_last = (col_nx >= side);
      if (cur_last) begin
         col_cnt_in = '0;
         row_cnt_in = (row_nx >= side) ? '0 : row_nx[CW-1:0];
      end else begin
         col_cnt_in = col_nx[CW-1:0];
         row_cnt_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (accept) begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage 1: window slide, ridge test, line store write-back
   // ---------------------------------------------------------------------
   logic          s1_valid_ff;
   logic [CW-1:0] s1_col_ff;
   logic [CW-1:0] s1_row_ff;
   logic          s1_last_ff;
   logic [LW-1:0] s1_below_ff;

   // previous row around the current column
   logic [LW-1:0] w1_ff, w2_ff;
   logic [LW-1:0] w0_in, w1_in, w2_in;
   // entry of the current column, fetched with the previous cell
   logic [crd_pkg::ENTRY_W-1:0] prev_ff;
   // column 0 lives here, since stage 0 of column 0 already reads column 1
   logic [LW-1:0] older0_ff, newer0_ff;

   logic [crd_pkg::ENTRY_W-1:0] rd_data;
   logic [LW-1:0] older_c, newer_c, mid;
   logic          col0, across, along, ridge;
   logic          s1_go;
   logic          pt_ready;
   crd_pkg::line_wr_type  wr;
   crd_pkg::point_req_type pt_req;

   always_comb begin
      col0 = (s1_col_ff == '0);
      if (col0) begin
         w0_in   = '0;
         w1_in   = newer0_ff;
         older_c = older0_ff;
         newer_c = newer0_ff;
      end else begin
         w0_in   = w1_ff;
         w1_in   = w2_ff;
         older_c = prev_ff[crd_pkg::ENTRY_W-1:LW];
         newer_c = prev_ff[LW-1:0];
      end
      w2_in  = s1_last_ff ? '0 : rd_data[LW-1:0];
      mid    = w1_in;
      across = (mid >= w0_in) && (mid >= w2_in);
      along  = (mid >= older_c) && (mid >= s1_below_ff);
      // border cells never qualify
      ridge  = (s1_row_ff >= CW'(2)) && !col0 && !s1_last_ff
             && (mid >= min_clearance_ff) && (across || along);
   end

   assign s1_go     = s1_valid_ff && (!ridge || pt_ready);
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!s1_valid_ff || s1_go) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= cur_col;
         s1_row_ff   <= cur_row;
         s1_last_ff  <= cur_last;
         s1_below_ff <= req_clearance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w1_ff <= '0;
         w2_ff <= '0;
      end else if (s1_go) begin
         w1_ff <= w1_in;
         w2_ff <= w2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         prev_ff <= rd_data;
         if (col0) begin
            older0_ff <= newer_c;
            newer0_ff <= s1_below_ff;
         end
      end
   end

   // rows shift down one: older <= newer, newer <= incoming cell
   always_comb begin
      wr.en   = s1_go;
      wr.addr = s1_col_ff;
      wr.data = {newer_c, s1_below_ff};
   end

   crd_line_store u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col_nx[CW-1:0]),
      .wr      (wr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------------
   // stages 2-3: world coordinates of the decided cell (row above)
   // ---------------------------------------------------------------------
   always_comb begin
      pt_req.col = crd_pkg::IDX_W'(s1_col_ff);
      pt_req.row = crd_pkg::IDX_W'(s1_row_ff - CW'(1));
   end

   crd_point_calc u_point_calc (
      .clock        (clock),
      .reset        (reset),
      .pt_valid     (s1_valid_ff && ridge),
      .pt_req       (pt_req),
      .pt_ready     (pt_ready),
      .cell_size    (cell_size_ff),
      .corner_x     (corner_x_ff),
      .corner_y     (corner_y_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_point_x  (rsp_point_x),
      .rsp_point_y  (rsp_point_y),
      .rsp_cell_col (rsp_cell_col),
      .rsp_cell_row (rsp_cell_row)
   );

endmodule
